// ----- rtl/core/dblf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dblf_pkg: shared types and constants of the deblocking edge line filter
// Request and result payload structs, configuration register indexes and
// sample and depth limits.
// ----------------------------------------------------------------------------
package dblf_pkg;

  localparam int unsigned SampleWidth = 12;
  localparam int unsigned StrengthWidth = 8;
  localparam int unsigned DepthWidth = 3;
  localparam int unsigned CfgIndexWidth = 1;

  // Depth codes above this saturate to 12-bit samples
  localparam logic [DepthWidth-1:0] MaxDepthMinus8 = 3'd4;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_LUMA_DEPTH   = 1'b0,
    REG_CHROMA_DEPTH = 1'b1
  } cfg_index_t;

  // Filter command
  typedef enum logic {
    CMD_LUMA   = 1'b0,
    CMD_CHROMA = 1'b1
  } command_t;

  typedef logic [SampleWidth-1:0] sample_t;

  typedef struct packed {
    command_t                 command;
    logic [StrengthWidth-1:0] strength;
    sample_t                  sample_p1;
    sample_t                  sample_p0;
    sample_t                  sample_q0;
    sample_t                  sample_q1;
  } line_req_t;

  typedef struct packed {
    sample_t out_p1;
    sample_t out_p0;
    sample_t out_q0;
    sample_t out_q1;
  } line_res_t;

endpackage

// ----- rtl/core/dblf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dblf_req_if / dblf_res_if: valid-ready channels of the edge line filter
// One carries a line of samples to filter, the other the filtered line.
// ----------------------------------------------------------------------------
interface dblf_req_if
  import dblf_pkg::*;
  ();
  logic      valid;
  logic      ready;
  line_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dblf_res_if
  import dblf_pkg::*;
  ();
  logic      valid;
  logic      ready;
  line_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/deblock_edge_line_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deblock_edge_line_filter_unit: one-line deblocking filter across an edge
// Filters p1 p0 | q0 q1 with a strength ramp, luma or chroma mode, and
// clamps the filtered samples to the configured bit depth.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | content
//  ---------+-----+---------------+------------------------------------------
//  req      | in  | valid / ready | command, strength, p1 p0 q0 q1
//  res      | out | valid / ready | filtered p1 p0 q0 q1
//  cfg      | in  | cfg_we        | cfg_index selects luma/chroma depth
//
//  A line passes an input register, then the filter arithmetic into the
//  result register. One line is accepted every cycle unless res stalls. On
//  a result stall both registers hold their lines; the input register keeps
//  taking requests as long as it is empty or the result register is free or
//  being drained. rst clears the valid flags and sets both depths to 8 bits.
//
module deblock_edge_line_filter_unit
  import dblf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  dblf_req_if.sink                 req,
  dblf_res_if.source               res,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [DepthWidth-1:0]    cfg_data
);

  // Clamp a signed working value into [0, maxv]
  function automatic sample_t clamp_px(input logic signed [15:0] v, input sample_t maxv);
    logic signed [15:0] hi;
    hi = signed'({4'b0, maxv});
    if (v < 16'sd0) begin
      return '0;
    end else if (v > hi) begin
      return maxv;
    end else begin
      return v[SampleWidth-1:0];
    end
  endfunction

  logic [DepthWidth-1:0] luma_depth;
  logic [DepthWidth-1:0] chroma_depth;

  logic      s1_valid;
  line_req_t s1;
  logic      s1_advance;

  logic      out_valid;
  line_res_t out_data;
  line_res_t out_data_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      luma_depth   <= '0;
      chroma_depth <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_LUMA_DEPTH:   luma_depth   <= cfg_data;
        REG_CHROMA_DEPTH: chroma_depth <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign s1_advance = !out_valid || res.ready;
  assign req.ready  = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1 <= req.payload;
    end
  end

  // Filter arithmetic
  logic [DepthWidth-1:0] dm8_raw;
  logic [DepthWidth-1:0] dm8;
  sample_t               st;
  sample_t               maxv;
  logic signed [15:0]    a_s, b_s, c_s, d_s;
  logic signed [15:0]    grad;
  logic signed [15:0]    d_q;
  sample_t               mag;
  logic signed [13:0]    over;
  logic [12:0]           ramp;
  sample_t               mag2;
  logic signed [15:0]    d1;
  logic signed [15:0]    outer;
  logic signed [15:0]    outer_q;
  logic signed [15:0]    lim;
  logic signed [15:0]    d2;

  always_comb begin
    dm8_raw = (s1.command == CMD_CHROMA) ? chroma_depth : luma_depth;
    dm8     = (dm8_raw > MaxDepthMinus8) ? MaxDepthMinus8 : dm8_raw;
    st      = sample_t'({4'b0, s1.strength}) << dm8;
    maxv    = sample_t'('1) >> (MaxDepthMinus8 - dm8);

    a_s = signed'({4'b0, s1.sample_p1});
    b_s = signed'({4'b0, s1.sample_p0});
    c_s = signed'({4'b0, s1.sample_q0});
    d_s = signed'({4'b0, s1.sample_q1});

    // d = (A - 4B + 4C - D) / 8, truncating toward zero
    grad = a_s - (b_s <<< 2) + (c_s <<< 2) - d_s;
    d_q  = (grad + (grad[15] ? 16'sd7 : 16'sd0)) >>> 3;
    mag  = d_q[15] ? SampleWidth'(-d_q) : d_q[SampleWidth-1:0];

    // Ramp: |d1| = max(0, |d| - max(0, 2(|d| - st)))
    over = signed'({2'b0, mag}) - signed'({2'b0, st});
    ramp = (over > 14'sd0) ? {over[11:0], 1'b0} : '0;
    mag2 = ({1'b0, mag} > ramp) ? SampleWidth'({1'b0, mag} - ramp) : '0;
    d1   = d_q[15] ? -signed'({4'b0, mag2}) : signed'({4'b0, mag2});

    // Outer correction: clip((A - D) / 4, +-|d1|/2)
    outer   = a_s - d_s;
    outer_q = (outer + (outer[15] ? 16'sd3 : 16'sd0)) >>> 2;
    lim     = signed'({5'b0, mag2[SampleWidth-1:1]});
    if (outer_q > lim) begin
      d2 = lim;
    end else if (outer_q < -lim) begin
      d2 = -lim;
    end else begin
      d2 = outer_q;
    end

    // Zero strength passes everything; chroma leaves the outer samples alone
    out_data_next.out_p1 = s1.sample_p1;
    out_data_next.out_p0 = s1.sample_p0;
    out_data_next.out_q0 = s1.sample_q0;
    out_data_next.out_q1 = s1.sample_q1;
    if (st != '0) begin
      out_data_next.out_p0 = clamp_px(b_s + d1, maxv);
      out_data_next.out_q0 = clamp_px(c_s - d1, maxv);
      if (s1.command == CMD_LUMA) begin
        out_data_next.out_p1 = clamp_px(a_s - d2, maxv);
        out_data_next.out_q1 = clamp_px(d_s + d2, maxv);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_data <= out_data_next;
    end
  end

  assign res.valid   = out_valid;
  assign res.payload = out_data;

endmodule
